[rtl/core/depth_hole_interpolation_fill_macros.svh]
// Assertion macros shared by the depth hole fill RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef DEPTH_HOLE_INTERPOLATION_FILL_MACROS_SVH
`define DEPTH_HOLE_INTERPOLATION_FILL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DHIF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define DHIF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dhif_pkg.sv]
// Package for the depth hole fill block: types, register codes, reset values.
// No dependencies.
`timescale 1ns / 1ps

package dhif_pkg;

    localparam int MAX_COLS_DEF = 640;
    localparam int MAX_ROWS_DEF = 480;
    localparam int DW           = 16;   // depth word width
    localparam int PAW          = 5;    // APB address width

    localparam logic [15:0] HOLE_THR_RST = 16'd100;
    localparam logic [15:0] JUMP_RST     = 16'd500;
    localparam logic [15:0] DISAGREE_RST = 16'd300;
    localparam logic [9:0]  MARGIN_RST   = 10'd10;
    localparam logic [9:0]  COLS_RST     = 10'd640;
    localparam logic [8:0]  ROWS_RST     = 9'd480;

    typedef enum logic [2:0] {
        REG_HOLE_THR = 3'd0,
        REG_JUMP     = 3'd1,
        REG_DISAGREE = 3'd2,
        REG_MARGIN   = 3'd3,
        REG_COLS     = 3'd4,
        REG_ROWS     = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_S_RD,
        ST_S_GET,
        ST_E_RD,
        ST_E_GET,
        ST_DIV_WAIT,
        ST_FILL
    } state_t;

    // Merge of row and column pass values.
    function automatic logic [DW-1:0] merge_px(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b,
                                               input logic [DW-1:0] lim);
        logic [DW-1:0] d;
        logic [DW:0]   sum;
        d   = (a > b) ? (a - b) : (b - a);
        sum = {1'b0, a} + {1'b0, b};
        if (a == '0 || b == '0)
            return '0;
        else if (d > lim)
            return (a > b) ? a : b;
        else
            return sum[DW:1];
    endfunction

endpackage

[rtl/core/dhif_div.sv]
// Restoring serial divider, one quotient bit per cycle (depth word / run length).
// Depends on dhif_pkg.
`timescale 1ns / 1ps

module dhif_div
    import dhif_pkg::*;
#(
    parameter int LW = 10
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [LW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quo,
    output logic [LW-1:0] rem
);

    localparam int DCW = $clog2(DW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [DCW-1:0] cnt_reg;
    logic [DW-1:0]  dvd_reg;
    logic [DW-1:0]  quo_reg;
    logic [LW-1:0]  rem_reg;
    logic [LW-1:0]  div_reg;
    logic [LW:0]    trial;
    logic           fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? LW'(trial - {1'b0, div_reg}) : trial[LW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/depth_hole_interpolation_fill.sv]
// Depth hole fill top level: frame memories, pass sequencer, merge and output.
// Depends on dhif_pkg, dhif_div and depth_hole_interpolation_fill_macros.svh.
//
//  channel | handshake              | words
//  --------+------------------------+-------------------------------
//  in      | in_valid / in_ready    | func, depth_in
//  out     | out_valid / out_ready  | depth_out, last
//  cfg     | APB psel/penable/pready| 6 regs at 4*i, pwdata/prdata
//
// A read word is read from the row and column memories into their read registers,
// then merged into the out register. The last load of a frame starts processing:
// a copy sweep of the raw frame, then per pass a scan of every pixel and a serial
// division per filled run of n+1 pixels. The copy sweep and the scan are bound
// by the single read port of the raw frame memory. in_ready is low during processing.
// Frame memories are not cleared after reset. A stalled out register holds the word.
`timescale 1ns / 1ps
`include "depth_hole_interpolation_fill_macros.svh"

module depth_hole_interpolation_fill
    import dhif_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)(
    input  logic           clk,
    input  logic           rst_n,
    // configuration
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    // input words
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           func,
    input  logic [DW-1:0]  depth_in,
    // output words
    output logic           out_valid,
    input  logic           out_ready,
    output logic [DW-1:0]  depth_out,
    output logic           last
);

    localparam int FRAME = MAX_COLS * MAX_ROWS;
    localparam int LW    = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
    localparam int AW    = $clog2(FRAME);
    localparam int CNTW  = $clog2(FRAME + 1);
    localparam int EW    = ((LW > 10) ? LW : 10) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] thr_reg;
    logic [15:0] jump_reg;
    logic [15:0] dis_reg;
    logic [9:0]  margin_reg;
    logic [9:0]  cols_reg;
    logic [8:0]  rows_reg;
    logic        cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= HOLE_THR_RST;
            jump_reg   <= JUMP_RST;
            dis_reg    <= DISAGREE_RST;
            margin_reg <= MARGIN_RST;
            cols_reg   <= COLS_RST;
            rows_reg   <= ROWS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_HOLE_THR: thr_reg    <= pwdata[15:0];
                REG_JUMP:     jump_reg   <= pwdata[15:0];
                REG_DISAGREE: dis_reg    <= pwdata[15:0];
                REG_MARGIN:   margin_reg <= pwdata[9:0];
                REG_COLS:     cols_reg   <= pwdata[9:0];
                REG_ROWS:     rows_reg   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_HOLE_THR: prdata = {16'b0, thr_reg};
            REG_JUMP:     prdata = {16'b0, jump_reg};
            REG_DISAGREE: prdata = {16'b0, dis_reg};
            REG_MARGIN:   prdata = {22'b0, margin_reg};
            REG_COLS:     prdata = {22'b0, cols_reg};
            REG_ROWS:     prdata = {23'b0, rows_reg};
            default:      prdata = '0;
        endcase
    end

    // Effective dimensions, clamped to [2, MAX]
    logic [LW-1:0]   w;
    logic [LW-1:0]   h;
    logic [2*LW-1:0] wh;
    logic [CNTW-1:0] total;

    always_comb
    begin
        if (cols_reg < 10'd2)
            w = LW'(2);
        else if (int'(cols_reg) > MAX_COLS)
            w = LW'(MAX_COLS);
        else
            w = LW'(cols_reg);
        if (rows_reg < 9'd2)
            h = LW'(2);
        else if (int'(rows_reg) > MAX_ROWS)
            h = LW'(MAX_ROWS);
        else
            h = LW'(rows_reg);
    end

    // Frame size follows a register write right away
    assign wh    = (2*LW)'(w) * (2*LW)'(h);
    assign total = CNTW'(wh);

    // ------------------------------------------------------------------
    // Control and pass registers
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic            pass_col_reg, pass_col_next;   // 0: row pass, 1: column pass
    logic [LW-1:0]   line_reg, line_next;
    logic [LW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   line_base_reg, line_base_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    logic            open_reg, open_next;
    logic [LW-1:0]   zs_reg, zs_next;
    logic [AW-1:0]   zs_addr_reg, zs_addr_next;
    logic [DW-1:0]   s_reg, s_next;
    logic            src_zero_reg, src_zero_next;
    logic            up_reg, up_next;
    logic [LW-1:0]   run_n_reg, run_n_next;
    logic [LW-1:0]   fill_i_reg, fill_i_next;
    logic [AW-1:0]   fill_addr_reg, fill_addr_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [LW-1:0]   r_reg, r_next;
    logic [CNTW-1:0] copy_k_reg, copy_k_next;
    logic            copy_wr_reg, copy_wr_next;
    logic [AW-1:0]   copy_waddr_reg, copy_waddr_next;
    logic [CNTW-1:0] ld_cnt_reg, ld_cnt_next;
    logic [CNTW-1:0] rd_cnt_reg, rd_cnt_next;
    logic            frame_ready_reg, frame_ready_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            rd_last_reg, rd_last_next;
    logic            out_valid_reg, out_valid_next;
    logic [DW-1:0]   out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;

    // Memory data
    logic [DW-1:0] raw_rdata_reg;
    logic [DW-1:0] row_rdata_reg;
    logic [DW-1:0] col_rdata_reg;
    logic [DW-1:0] img_rdata;

    // Handshake
    logic            accept;
    logic            do_load;
    logic            do_read;
    logic [CNTW-1:0] ld_idx;
    logic [CNTW-1:0] rd_idx;
    logic            ld_last;
    logic            rd_last;

    // Pass geometry
    logic [LW-1:0] lines;
    logic [LW-1:0] len;
    logic [AW-1:0] lstep;    // address step to the next line
    logic [AW-1:0] pstep;    // address step along the line
    logic          last_pos;

    // Combinational pass helpers
    logic [AW-1:0] img_raddr;
    logic          fill_we;
    logic [DW-1:0] fill_val;
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic [LW-1:0] div_rem;
    logic          hole;
    logic          skip;
    logic [EW-1:0] zs_e, p_e, em_e, len_e;
    logic [DW-1:0] e_v, s_v, diff;
    logic [LW:0]   r_sum;
    logic          do_adv;

    assign in_ready = (state_reg == ST_IDLE) && !rd_pend_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid & in_ready;
    assign do_load  = accept & !func;
    assign do_read  = accept & func & frame_ready_reg;

    assign ld_idx  = (ld_cnt_reg >= total) ? '0 : ld_cnt_reg;
    assign rd_idx  = (rd_cnt_reg >= total) ? '0 : rd_cnt_reg;
    assign ld_last = (CNTW'(ld_idx + 1'b1) == total);
    assign rd_last = (CNTW'(rd_idx + 1'b1) == total);

    assign lines    = pass_col_reg ? w : h;
    assign len      = pass_col_reg ? h : w;
    assign lstep    = pass_col_reg ? AW'(1) : AW'(w);
    assign pstep    = pass_col_reg ? AW'(w) : AW'(1);
    assign last_pos = (LW'(pos_reg + 1'b1) == len);

    assign img_rdata = pass_col_reg ? col_rdata_reg : row_rdata_reg;

    // Run edge test against the scanned line length
    assign zs_e  = EW'(zs_reg);
    assign p_e   = EW'(pos_reg);
    assign em_e  = EW'(margin_reg);
    assign len_e = EW'(len);
    assign skip  = (zs_e < em_e) && (p_e + em_e > len_e);
    assign hole  = (raw_rdata_reg < thr_reg) && !last_pos;

    // Interpolated value: s + floor(d*i/n) going up, s - ceil(d*i/n) going down
    assign fill_val = up_reg ? (s_reg + q_reg)
                             : (s_reg - q_reg - DW'(r_reg != '0));
    assign r_sum    = {1'b0, r_reg} + {1'b0, div_rem};

    always_comb
    begin
        state_next       = state_reg;
        pass_col_next    = pass_col_reg;
        line_next        = line_reg;
        pos_next         = pos_reg;
        line_base_next   = line_base_reg;
        scan_addr_next   = scan_addr_reg;
        open_next        = open_reg;
        zs_next          = zs_reg;
        zs_addr_next     = zs_addr_reg;
        s_next           = s_reg;
        src_zero_next    = src_zero_reg;
        up_next          = up_reg;
        run_n_next       = run_n_reg;
        fill_i_next      = fill_i_reg;
        fill_addr_next   = fill_addr_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        copy_k_next      = copy_k_reg;
        copy_wr_next     = 1'b0;
        copy_waddr_next  = copy_waddr_reg;
        ld_cnt_next      = ld_cnt_reg;
        rd_cnt_next      = rd_cnt_reg;
        frame_ready_next = frame_ready_reg;
        rd_pend_next     = do_read;
        rd_last_next     = rd_last_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        img_raddr        = scan_addr_reg;
        fill_we          = 1'b0;
        div_start        = 1'b0;
        div_dividend     = '0;
        e_v              = '0;
        s_v              = s_reg;
        diff             = '0;
        do_adv           = 1'b0;

        // Output register
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = merge_px(row_rdata_reg, col_rdata_reg, dis_reg);
            out_last_next  = rd_last_reg;
        end

        // Read word
        if (do_read)
        begin
            rd_last_next = rd_last;
            if (rd_last)
            begin
                rd_cnt_next      = '0;
                frame_ready_next = 1'b0;
            end
            else
                rd_cnt_next = CNTW'(rd_idx + 1'b1);
        end

        // Load word; the last one of a frame starts processing
        if (do_load)
        begin
            if (ld_last)
            begin
                ld_cnt_next      = '0;
                rd_cnt_next      = '0;
                frame_ready_next = 1'b0;
                copy_k_next      = '0;
                state_next       = ST_COPY;
            end
            else
                ld_cnt_next = CNTW'(ld_idx + 1'b1);
        end

        unique case (state_reg)
            ST_IDLE: ;

            ST_COPY:
            begin
                copy_wr_next    = 1'b1;
                copy_waddr_next = copy_k_reg[AW-1:0];
                if (CNTW'(copy_k_reg + 1'b1) == total)
                begin
                    pass_col_next  = 1'b0;
                    line_next      = '0;
                    pos_next       = '0;
                    line_base_next = '0;
                    scan_addr_next = '0;
                    open_next      = 1'b0;
                    state_next     = ST_SCAN_RD;
                end
                else
                    copy_k_next = copy_k_reg + 1'b1;
            end

            ST_SCAN_RD:
                state_next = ST_SCAN_CHK;

            ST_SCAN_CHK:
            begin
                if (hole)
                begin
                    if (!open_reg)
                    begin
                        open_next    = 1'b1;
                        zs_next      = pos_reg;
                        zs_addr_next = scan_addr_reg;
                    end
                    do_adv = 1'b1;
                end
                else if (!open_reg)
                    do_adv = 1'b1;
                else
                begin
                    open_next = 1'b0;
                    if (skip)
                        do_adv = 1'b1;
                    else
                        state_next = ST_S_RD;
                end
            end

            ST_S_RD:
            begin
                // previous pixel on the line, else same position on the previous line
                img_raddr     = (zs_reg != '0) ? (zs_addr_reg - pstep) : (zs_addr_reg - lstep);
                src_zero_next = (zs_reg == '0) && (line_reg == '0);
                state_next    = ST_S_GET;
            end

            ST_S_GET:
            begin
                s_next     = src_zero_reg ? '0 : img_rdata;
                state_next = ST_E_RD;
            end

            ST_E_RD:
            begin
                img_raddr     = last_pos ? (scan_addr_reg - lstep) : scan_addr_reg;
                src_zero_next = last_pos && (line_reg == '0);
                state_next    = ST_E_GET;
            end

            ST_E_GET:
            begin
                e_v  = src_zero_reg ? '0 : img_rdata;
                diff = (s_reg > e_v) ? (s_reg - e_v) : (e_v - s_reg);
                if (!last_pos && (diff > jump_reg))
                begin
                    if (e_v < s_reg)
                        e_v = s_reg;
                    else
                        s_v = e_v;
                end
                up_next        = (e_v >= s_v);
                div_dividend   = (e_v >= s_v) ? (e_v - s_v) : (s_v - e_v);
                div_start      = 1'b1;
                s_next         = s_v;
                run_n_next     = pos_reg - zs_reg;
                fill_addr_next = zs_addr_reg;
                fill_i_next    = '0;
                q_next         = '0;
                r_next         = '0;
                state_next     = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ST_FILL;
            end

            ST_FILL:
            begin
                fill_we = 1'b1;
                if (fill_i_reg == run_n_reg)
                    do_adv = 1'b1;
                else
                begin
                    fill_i_next    = fill_i_reg + 1'b1;
                    fill_addr_next = fill_addr_reg + pstep;
                    if (r_sum >= {1'b0, run_n_reg})
                    begin
                        r_next = LW'(r_sum - {1'b0, run_n_reg});
                        q_next = q_reg + div_quo + 1'b1;
                    end
                    else
                    begin
                        r_next = r_sum[LW-1:0];
                        q_next = q_reg + div_quo;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Step to the next pixel, line or pass, or back to idle after the column pass
        if (do_adv)
        begin
            if (last_pos)
            begin
                open_next = 1'b0;
                pos_next  = '0;
                if (LW'(line_reg + 1'b1) == lines)
                begin
                    if (pass_col_reg)
                    begin
                        frame_ready_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        pass_col_next  = 1'b1;
                        line_next      = '0;
                        line_base_next = '0;
                        scan_addr_next = '0;
                        state_next     = ST_SCAN_RD;
                    end
                end
                else
                begin
                    line_next      = line_reg + 1'b1;
                    line_base_next = line_base_reg + lstep;
                    scan_addr_next = line_base_reg + lstep;
                    state_next     = ST_SCAN_RD;
                end
            end
            else
            begin
                pos_next       = pos_reg + 1'b1;
                scan_addr_next = scan_addr_reg + pstep;
                state_next     = ST_SCAN_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pass_col_reg    <= 1'b0;
            line_reg        <= '0;
            pos_reg         <= '0;
            line_base_reg   <= '0;
            scan_addr_reg   <= '0;
            open_reg        <= 1'b0;
            fill_i_reg      <= '0;
            run_n_reg       <= '0;
            copy_k_reg      <= '0;
            copy_wr_reg     <= 1'b0;
            ld_cnt_reg      <= '0;
            rd_cnt_reg      <= '0;
            frame_ready_reg <= 1'b0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_col_reg    <= pass_col_next;
            line_reg        <= line_next;
            pos_reg         <= pos_next;
            line_base_reg   <= line_base_next;
            scan_addr_reg   <= scan_addr_next;
            open_reg        <= open_next;
            fill_i_reg      <= fill_i_next;
            run_n_reg       <= run_n_next;
            copy_k_reg      <= copy_k_next;
            copy_wr_reg     <= copy_wr_next;
            ld_cnt_reg      <= ld_cnt_next;
            rd_cnt_reg      <= rd_cnt_next;
            frame_ready_reg <= frame_ready_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        zs_reg         <= zs_next;
        zs_addr_reg    <= zs_addr_next;
        s_reg          <= s_next;
        src_zero_reg   <= src_zero_next;
        up_reg         <= up_next;
        fill_addr_reg  <= fill_addr_next;
        q_reg          <= q_next;
        r_reg          <= r_next;
        copy_waddr_reg <= copy_waddr_next;
        rd_last_reg    <= rd_last_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Frame memories
    // ------------------------------------------------------------------
    logic [DW-1:0] raw_mem [FRAME];
    logic [DW-1:0] row_mem [FRAME];
    logic [DW-1:0] col_mem [FRAME];
    logic [AW-1:0] raw_raddr;
    logic [AW-1:0] pass_raddr;
    logic [AW-1:0] img_waddr;
    logic [DW-1:0] img_wdata;
    logic          row_we;
    logic          col_we;

    assign raw_raddr  = (state_reg == ST_COPY) ? copy_k_reg[AW-1:0] : scan_addr_reg;
    assign pass_raddr = (state_reg == ST_IDLE) ? rd_idx[AW-1:0] : img_raddr;
    assign img_waddr  = copy_wr_reg ? copy_waddr_reg : fill_addr_reg;
    assign img_wdata  = copy_wr_reg ? raw_rdata_reg : fill_val;
    assign row_we     = copy_wr_reg | (fill_we & !pass_col_reg);
    assign col_we     = copy_wr_reg | (fill_we & pass_col_reg);

    always_ff @(posedge clk)
    begin
        if (do_load)
            raw_mem[ld_idx[AW-1:0]] <= depth_in;
        raw_rdata_reg <= raw_mem[raw_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[img_waddr] <= img_wdata;
        row_rdata_reg <= row_mem[pass_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[img_waddr] <= img_wdata;
        col_rdata_reg <= col_mem[pass_raddr];
    end

    // ------------------------------------------------------------------
    // Run slope divider: |e - s| / n once per run
    // ------------------------------------------------------------------
    dhif_div #(
        .LW (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pos_reg - zs_reg),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    assign out_valid = out_valid_reg;
    assign depth_out = out_data_reg;
    assign last      = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DHIF_ASSERT_IMP(a_ready_idle, in_ready, state_reg == ST_IDLE, "word taken while busy")
    `DHIF_ASSERT_NXT(a_read_out, rd_pend_reg, out_valid_reg, "read word lost before output")
    `DHIF_ASSERT_IMP(a_fill_bound, state_reg == ST_FILL, fill_i_reg <= run_n_reg, "fill past run")
    `DHIF_ASSERT_IMP(a_busy_ready, state_reg != ST_IDLE, !frame_ready_reg, "ready during passes")

endmodule
